@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/mer_pkg.sv @@
// ----------------------------------------------------------------------------
// mer_pkg
// Types shared by the ellipse rasterizer sequencer and its multiply unit.
// ----------------------------------------------------------------------------
package mer_pkg;

    // Accumulator base for one multiply-accumulate operation
    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_ACC,
        BASE_EXT
    } base_sel_t;

    // Control word that travels with an operation through the unit
    typedef struct packed {
        logic      en;
        logic      sub;
        base_sel_t base;
    } mac_ctl_t;

endpackage

@@ rtl/mer_mac.sv @@
// ----------------------------------------------------------------------------
// mer_mac
// Shared two-stage multiply-accumulate unit: product register, then
// acc = base +/- product in the accumulator register.
// ----------------------------------------------------------------------------
module mer_mac #(
    parameter int AW = 34,
    parameter int BW = 14
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mer_pkg::mac_ctl_t       ctl,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    input  logic signed [AW+BW-1:0] ext,
    output logic signed [AW+BW-1:0] acc
);

    localparam int PW = AW + BW;

    mer_pkg::mac_ctl_t    ctl_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] acc_next;
    logic signed [PW-1:0] base_val;

    // Stage 1: multiply, operands sign-extended to the full product width
    assign prod_next = PW'(a) * PW'(b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Stage 2: accumulate onto the selected base
    always_comb
    begin
        case (ctl_reg.base)
            mer_pkg::BASE_ZERO: base_val = '0;
            mer_pkg::BASE_ACC:  base_val = acc_reg;
            mer_pkg::BASE_EXT:  base_val = ext;
            default:            base_val = '0;
        endcase
        if (ctl_reg.en)
        begin
            acc_next = ctl_reg.sub ? (base_val - prod_reg) : (base_val + prod_reg);
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    assign acc = acc_reg;

endmodule

@@ rtl/midpoint_ellipse_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core
// Midpoint ellipse rasterizer: one request in, one result of four points out.
// ----------------------------------------------------------------------------
// A start request (operation 0) loads center and radii and returns a result
// with valid_res low; each step request (operation 1) returns the four
// symmetric points of the current position and advances the decision
// variable, with last high on the final group. All products go through one
// shared two-stage multiply-accumulate unit driven by a small sequencer, so
// the block takes one request at a time: a start runs LOAD then ZERO, a step
// in region 2 runs UPDATE, a step in region 1 runs TEST then UPDATE (region
// test plus update), the step that changes region runs TEST, SWITCH and
// UPDATE, and a step while idle runs ZERO. A finished result waits in the
// output register while the next request is accepted.
module midpoint_ellipse_rasterizer_core #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic                         operation,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic [RADIUS_BITS-1:0]       radius_x,
    input  logic [RADIUS_BITS-1:0]       radius_y,
    // result channel
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic                         valid_res,
    output logic                         last,
    output logic signed [COORD_BITS:0]   px_right_top,
    output logic signed [COORD_BITS:0]   py_right_top,
    output logic signed [COORD_BITS:0]   px_left_bottom,
    output logic signed [COORD_BITS:0]   py_left_bottom,
    output logic signed [COORD_BITS:0]   px_right_bottom,
    output logic signed [COORD_BITS:0]   py_right_bottom,
    output logic signed [COORD_BITS:0]   px_left_top,
    output logic signed [COORD_BITS:0]   py_left_top
);

`include "assert_macros.svh"

    localparam int CW = COORD_BITS;
    localparam int RW = RADIUS_BITS;
    localparam int OW = CW + 1;
    localparam int XW = RW + 1;
    localparam int YW = RW + 2;
    localparam int AW = 3 * RW + 4;
    localparam int BW = RW + 4;
    localparam int DW = AW + BW;
    localparam int SW = ((CW > YW) ? CW : YW) + 2;

    localparam logic [2:0] LOAD_DONE   = 3'd6;
    localparam logic [2:0] SWITCH_DONE = 3'd6;
    localparam logic [2:0] TEST_DONE   = 3'd3;
    localparam logic [2:0] UPD_DONE    = 3'd3;

    localparam logic signed [BW-1:0] B_ONE   = BW'(1);
    localparam logic signed [BW-1:0] B_TWO   = BW'(2);
    localparam logic signed [BW-1:0] B_THREE = BW'(3);
    localparam logic signed [BW-1:0] B_FOUR  = BW'(4);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TEST,
        ST_SWITCH,
        ST_UPDATE,
        ST_ZERO
    } state_t;

    state_t                 state_reg,  state_next;
    logic [2:0]             cnt_reg,    cnt_next;
    logic                   active_reg, active_next;
    logic                   reg2_reg,   reg2_next;
    logic signed [CW-1:0]   cx_reg,     cx_next;
    logic signed [CW-1:0]   cy_reg,     cy_next;
    logic [RW-1:0]          rx_reg,     rx_next;
    logic [RW-1:0]          ry_reg,     ry_next;
    logic [2*RW-1:0]        rx2_reg,    rx2_next;
    logic [2*RW-1:0]        ry2_reg,    ry2_next;
    logic signed [AW-1:0]   nrr_reg,    nrr_next;
    logic signed [AW-1:0]   t1_reg,     t1_next;
    logic signed [AW-1:0]   t2_reg,     t2_next;
    logic [XW-1:0]          x_reg,      x_next;
    logic signed [YW-1:0]   y_reg,      y_next;
    logic signed [DW-1:0]   dec_reg,    dec_next;

    logic                   rsp_valid_reg, rsp_valid_next;
    logic                   vres_reg,      vres_next;
    logic                   last_reg,      last_next;
    logic signed [OW-1:0]   pxr_reg, pxr_next;
    logic signed [OW-1:0]   pxl_reg, pxl_next;
    logic signed [OW-1:0]   pyt_reg, pyt_next;
    logic signed [OW-1:0]   pyb_reg, pyb_next;

    // shared unit hookup
    mer_pkg::mac_ctl_t      mac_ctl;
    logic signed [AW-1:0]   mac_a;
    logic signed [BW-1:0]   mac_b;
    logic signed [DW-1:0]   acc;

    mer_mac #(
        .AW (AW),
        .BW (BW)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .ext   (dec_reg),
        .acc   (acc)
    );

    // operand views
    logic signed [AW-1:0] rx_a, ry_a, rx2_a, ry2_a, rx2q_a;
    logic signed [BW-1:0] rx_b, ry_b, ry4_b, x_b, y_b;
    logic signed [BW-1:0] x2p1_b, x2p2_b, x2p3_b, y2_b, ym1_b, ym1x4_b;
    logic signed [BW-1:0] kx_b, ky_b;
    logic                 dec_neg, dec_pos, acc_neg, out_free;
    logic signed [DW-1:0] p4_adj;
    logic [XW-1:0]        x_upd;
    logic signed [YW-1:0] y_upd;
    logic signed [SW-1:0] cx_s, cy_s, x_s, y_s;
    logic signed [SW-1:0] xp_s, xm_s, yp_s, ym_s;

    assign rx_a    = {{(AW-RW){1'b0}}, rx_reg};
    assign ry_a    = {{(AW-RW){1'b0}}, ry_reg};
    assign rx2_a   = {{(AW-2*RW){1'b0}}, rx2_reg};
    assign ry2_a   = {{(AW-2*RW){1'b0}}, ry2_reg};
    assign rx2q_a  = {{(AW-2*RW+2){1'b0}}, rx2_reg[2*RW-1:2]};
    assign rx_b    = {{(BW-RW){1'b0}}, rx_reg};
    assign ry_b    = {{(BW-RW){1'b0}}, ry_reg};
    assign ry4_b   = {ry_b[BW-3:0], 2'b00};
    assign x_b     = {{(BW-XW){1'b0}}, x_reg};
    assign y_b     = {{(BW-YW){y_reg[YW-1]}}, y_reg};
    assign x2p1_b  = {x_b[BW-2:0], 1'b1};
    assign x2p2_b  = x2p1_b + B_ONE;
    assign x2p3_b  = x2p1_b + B_TWO;
    assign y2_b    = {y_b[BW-2:0], 1'b0};
    assign ym1_b   = y_b - B_ONE;
    assign ym1x4_b = {y_b[BW-3:0], 2'b00} - B_FOUR;

    assign dec_neg  = dec_reg[DW-1];
    assign dec_pos  = !dec_reg[DW-1] && (dec_reg != '0);
    assign acc_neg  = acc[DW-1];
    assign out_free = !rsp_valid_reg || rsp_ready;

    // P4 / 4 truncated toward zero
    assign p4_adj = acc + {{(DW-2){1'b0}}, acc[DW-1], acc[DW-1]};

    // Update multipliers: d += ry2*kx - rx2*ky, and the next position
    always_comb
    begin
        if (!reg2_reg)
        begin
            kx_b  = x2p3_b;
            ky_b  = dec_neg ? '0 : (y2_b - B_TWO);
            x_upd = x_reg + XW'(1);
            y_upd = dec_neg ? y_reg : (y_reg - YW'(1));
        end
        else
        begin
            kx_b  = dec_pos ? '0 : x2p2_b;
            ky_b  = dec_pos ? (y2_b - B_THREE) : (y2_b - B_ONE);
            x_upd = dec_pos ? x_reg : (x_reg + XW'(1));
            y_upd = y_reg - YW'(1);
        end
    end

    // Symmetric points, wrapped to the output width
    assign cx_s = {{(SW-CW){cx_reg[CW-1]}}, cx_reg};
    assign cy_s = {{(SW-CW){cy_reg[CW-1]}}, cy_reg};
    assign x_s  = {{(SW-XW){1'b0}}, x_reg};
    assign y_s  = {{(SW-YW){y_reg[YW-1]}}, y_reg};
    assign xp_s = cx_s + x_s;
    assign xm_s = cx_s - x_s;
    assign yp_s = cy_s + y_s;
    assign ym_s = cy_s - y_s;

    assign req_ready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        active_next    = active_reg;
        reg2_next      = reg2_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        rx2_next       = rx2_reg;
        ry2_next       = ry2_reg;
        nrr_next       = nrr_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        dec_next       = dec_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        vres_next      = vres_reg;
        last_next      = last_reg;
        pxr_next       = pxr_reg;
        pxl_next       = pxl_reg;
        pyt_next       = pyt_reg;
        pyb_next       = pyb_reg;
        mac_ctl        = '{en: 1'b0, sub: 1'b0, base: mer_pkg::BASE_ZERO};
        mac_a          = '0;
        mac_b          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (req_valid)
                begin
                    if (!operation)
                    begin
                        cx_next    = center_x;
                        cy_next    = center_y;
                        rx_next    = radius_x;
                        ry_next    = radius_y;
                        state_next = ST_LOAD;
                    end
                    else if (!active_reg)
                    begin
                        state_next = ST_ZERO;
                    end
                    else if (reg2_reg)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_TEST;
                    end
                end
            end

            // rx2, ry2, -rx2*ry and the initial decision
            ST_LOAD:
            begin
                cnt_next = cnt_reg + 3'd1;
                case (cnt_reg)
                    3'd0:
                    begin
                        mac_ctl = '{en: 1'b1, sub: 1'b0, base: mer_pkg::BASE_ZERO};
                        mac_a   = rx_a;
                        mac_b   = rx_b;
                    end
                    3'd1:
                    begin
                        mac_ctl = '{en: 1'b1, sub: 1'b0, base: mer_pkg::BASE_ZERO};
                        mac_a   = ry_a;
                        mac_b   = ry_b;
                    end
                    3'd2:
                    begin
                        rx2_next = acc[2*RW-1:0];
                        mac_ctl  = '{en: 1'b1, sub: 1'b1, base: mer_pkg::BASE_ZERO};
                        mac_a    = acc[AW-1:0];
                        mac_b    = ry_b;
                    end
                    3'd3:
                    begin
                        ry2_next = acc[2*RW-1:0];
                        mac_ctl  = '{en: 1'b1, sub: 1'b0, base: mer_pkg::BASE_ACC};
                        mac_a    = rx2q_a;
                        mac_b    = B_ONE;
                    end
                    3'd4:
                    begin
                        nrr_next = acc[AW-1:0];
                        mac_ctl  = '{en: 1'b1, sub: 1'b0, base: mer_pkg::BASE_ACC};
                        mac_a    = ry2_a;
                        mac_b    = B_ONE;
                    end
                    default:
                    begin
                    end
                endcase
                if (cnt_reg == LOAD_DONE)
                begin
                    dec_next    = acc;
                    x_next      = '0;
                    y_next      = {{(YW-RW){1'b0}}, ry_reg};
                    reg2_next   = 1'b0;
                    active_next = 1'b1;
                    state_next  = ST_ZERO;
                end
            end

            // region-1 test: x*ry2 - y*rx2 < 0
            ST_TEST:
            begin
                cnt_next = cnt_reg + 3'd1;
                case (cnt_reg)
                    3'd0:
                    begin
                        mac_ctl = '{en: 1'b1, sub: 1'b0, base: mer_pkg::BASE_ZERO};
                        mac_a   = ry2_a;
                        mac_b   = x_b;
                    end
                    3'd1:
                    begin
                        mac_ctl = '{en: 1'b1, sub: 1'b1, base: mer_pkg::BASE_ACC};
                        mac_a   = rx2_a;
                        mac_b   = y_b;
                    end
                    default:
                    begin
                    end
                endcase
                if (cnt_reg == TEST_DONE)
                begin
                    cnt_next   = '0;
                    state_next = acc_neg ? ST_UPDATE : ST_SWITCH;
                end
            end

            // region change: P4 = (2x+1)^2 ry2 + 4(y-1)^2 rx2 - 4 rx2 ry2
            ST_SWITCH:
            begin
                cnt_next = cnt_reg + 3'd1;
                case (cnt_reg)
                    3'd0:
                    begin
                        mac_ctl = '{en: 1'b1, sub: 1'b0, base: mer_pkg::BASE_ZERO};
                        mac_a   = ry2_a;
                        mac_b   = x2p1_b;
                    end
                    3'd1:
                    begin
                        mac_ctl = '{en: 1'b1, sub: 1'b0, base: mer_pkg::BASE_ZERO};
                        mac_a   = rx2_a;
                        mac_b   = ym1_b;
                    end
                    3'd2:
                    begin
                        t1_next = acc[AW-1:0];
                        mac_ctl = '{en: 1'b1, sub: 1'b0, base: mer_pkg::BASE_ZERO};
                        mac_a   = nrr_reg;
                        mac_b   = ry4_b;
                    end
                    3'd3:
                    begin
                        t2_next = acc[AW-1:0];
                        mac_ctl = '{en: 1'b1, sub: 1'b0, base: mer_pkg::BASE_ACC};
                        mac_a   = t1_reg;
                        mac_b   = x2p1_b;
                    end
                    3'd4:
                    begin
                        mac_ctl = '{en: 1'b1, sub: 1'b0, base: mer_pkg::BASE_ACC};
                        mac_a   = t2_reg;
                        mac_b   = ym1x4_b;
                    end
                    default:
                    begin
                    end
                endcase
                if (cnt_reg == SWITCH_DONE)
                begin
                    dec_next   = p4_adj >>> 2;
                    reg2_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_UPDATE;
                end
            end

            // decision update, emit current points, advance position
            ST_UPDATE:
            begin
                if (cnt_reg != UPD_DONE)
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
                case (cnt_reg)
                    3'd0:
                    begin
                        mac_ctl = '{en: 1'b1, sub: 1'b0, base: mer_pkg::BASE_EXT};
                        mac_a   = ry2_a;
                        mac_b   = kx_b;
                    end
                    3'd1:
                    begin
                        mac_ctl = '{en: 1'b1, sub: 1'b1, base: mer_pkg::BASE_ACC};
                        mac_a   = rx2_a;
                        mac_b   = ky_b;
                    end
                    default:
                    begin
                    end
                endcase
                if ((cnt_reg == UPD_DONE) && out_free)
                begin
                    rsp_valid_next = 1'b1;
                    vres_next      = 1'b1;
                    last_next      = reg2_reg && y_upd[YW-1];
                    pxr_next       = xp_s[OW-1:0];
                    pxl_next       = xm_s[OW-1:0];
                    pyt_next       = ym_s[OW-1:0];
                    pyb_next       = yp_s[OW-1:0];
                    dec_next       = acc;
                    x_next         = x_upd;
                    y_next         = y_upd;
                    active_next    = !(reg2_reg && y_upd[YW-1]);
                    state_next     = ST_IDLE;
                end
            end

            // result with no pixels (start, or step while idle)
            ST_ZERO:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    vres_next      = 1'b0;
                    last_next      = 1'b0;
                    pxr_next       = '0;
                    pxl_next       = '0;
                    pyt_next       = '0;
                    pyb_next       = '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            reg2_reg      <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            rx_reg        <= '0;
            ry_reg        <= '0;
            rx2_reg       <= '0;
            ry2_reg       <= '0;
            nrr_reg       <= '0;
            t1_reg        <= '0;
            t2_reg        <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            dec_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            vres_reg      <= 1'b0;
            last_reg      <= 1'b0;
            pxr_reg       <= '0;
            pxl_reg       <= '0;
            pyt_reg       <= '0;
            pyb_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            active_reg    <= active_next;
            reg2_reg      <= reg2_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            rx_reg        <= rx_next;
            ry_reg        <= ry_next;
            rx2_reg       <= rx2_next;
            ry2_reg       <= ry2_next;
            nrr_reg       <= nrr_next;
            t1_reg        <= t1_next;
            t2_reg        <= t2_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            dec_reg       <= dec_next;
            rsp_valid_reg <= rsp_valid_next;
            vres_reg      <= vres_next;
            last_reg      <= last_next;
            pxr_reg       <= pxr_next;
            pxl_reg       <= pxl_next;
            pyt_reg       <= pyt_next;
            pyb_reg       <= pyb_next;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign valid_res       = vres_reg;
    assign last            = last_reg;
    assign px_right_top    = pxr_reg;
    assign py_right_top    = pyt_reg;
    assign px_left_bottom  = pxl_reg;
    assign py_left_bottom  = pyb_reg;
    assign px_right_bottom = pxr_reg;
    assign py_right_bottom = pyb_reg;
    assign px_left_top     = pxl_reg;
    assign py_left_top     = pyt_reg;

    // Checks
    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready, "ready after accept")
    `ASSERT_IMPLIES(a_last_has_pixels, clk, rst_n, rsp_valid && last, valid_res, "last without pixels")
    `ASSERT_IMPLIES(a_y_nonneg_active, clk, rst_n, active_reg, !y_reg[YW-1], "negative y while active")

endmodule

@@ test/midpoint_ellipse_rasterizer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core_tb
// Self-checking bench for the midpoint ellipse rasterizer. Start and step
// requests go in over a valid/ready channel. A software rasterizer in the
// bench tracks center, radii, position and decision term, and predicts each
// pixel group. Every returned result is compared field by field with the
// oldest prediction. Both channels stall at random.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core_tb;

    localparam int COORD_BITS      = 12;
    localparam int RADIUS_BITS     = 10;
    localparam int OUT_BITS        = COORD_BITS + 1;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_REQUESTS = 1650;
    localparam int STEADY_REQUESTS = 350;
    localparam int FULL_RUN_CAP    = 200;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_PRINTS      = 40;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // One predicted pixel group
    typedef struct packed {
        logic                       valid_res;
        logic                       last;
        logic signed [OUT_BITS-1:0] px_rt;
        logic signed [OUT_BITS-1:0] py_rt;
        logic signed [OUT_BITS-1:0] px_lb;
        logic signed [OUT_BITS-1:0] py_lb;
        logic signed [OUT_BITS-1:0] px_rb;
        logic signed [OUT_BITS-1:0] py_rb;
        logic signed [OUT_BITS-1:0] px_lt;
        logic signed [OUT_BITS-1:0] py_lt;
    } pixel_group_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Request channel
    logic                         req_valid = 1'b0;
    logic                         req_ready;
    logic                         operation = 1'b0;
    logic signed [COORD_BITS-1:0] center_x  = '0;
    logic signed [COORD_BITS-1:0] center_y  = '0;
    logic [RADIUS_BITS-1:0]       radius_x  = '0;
    logic [RADIUS_BITS-1:0]       radius_y  = '0;

    // Result channel
    logic                       rsp_valid;
    logic                       rsp_ready = 1'b0;
    logic                       valid_res;
    logic                       last;
    logic signed [OUT_BITS-1:0] px_right_top;
    logic signed [OUT_BITS-1:0] py_right_top;
    logic signed [OUT_BITS-1:0] px_left_bottom;
    logic signed [OUT_BITS-1:0] py_left_bottom;
    logic signed [OUT_BITS-1:0] px_right_bottom;
    logic signed [OUT_BITS-1:0] py_right_bottom;
    logic signed [OUT_BITS-1:0] px_left_top;
    logic signed [OUT_BITS-1:0] py_left_top;

    // Rasterizer state as the bench sees it
    bit     ell_active;
    bit     ell_region_two;
    longint ell_x;
    longint ell_y;
    longint ell_p;
    longint ell_cx;
    longint ell_cy;
    longint ell_rx;
    longint ell_ry;

    pixel_group_t expected_groups[$];

    bit quiet_mode    = 1'b0;
    int n_requests    = 0;
    int n_errors      = 0;
    int n_groups      = 0;
    int n_finished    = 0;
    int n_region_swap = 0;
    int cycle_count   = 0;

    midpoint_ellipse_rasterizer_core #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .operation       (operation),
        .center_x        (center_x),
        .center_y        (center_y),
        .radius_x        (radius_x),
        .radius_y        (radius_y),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .valid_res       (valid_res),
        .last            (last),
        .px_right_top    (px_right_top),
        .py_right_top    (py_right_top),
        .px_left_bottom  (px_left_bottom),
        .py_left_bottom  (py_left_bottom),
        .px_right_bottom (px_right_bottom),
        .py_right_bottom (py_right_bottom),
        .px_left_top     (px_left_top),
        .py_left_top     (py_left_top)
    );

    always #5 clk = ~clk;

    // Run-length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_groups.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Result-side backpressure
    always @(posedge clk)
    begin
        rsp_ready <= quiet_mode || ($urandom_range(99) >= 15);
    end

    // Bench rasterizer: one request in, one predicted pixel group out
    function automatic pixel_group_t rasterize(op_t op,
                                               logic signed [COORD_BITS-1:0] cx,
                                               logic signed [COORD_BITS-1:0] cy,
                                               logic [RADIUS_BITS-1:0] rx,
                                               logic [RADIUS_BITS-1:0] ry);
        pixel_group_t g;
        longint       rx2;
        longint       ry2;
        longint       a;
        longint       b;
        g = '0;
        if (op == OP_START)
        begin
            ell_cx = longint'(cx);
            ell_cy = longint'(cy);
            ell_rx = longint'(rx);
            ell_ry = longint'(ry);
            rx2 = ell_rx * ell_rx;
            ry2 = ell_ry * ell_ry;
            ell_x = 0;
            ell_y = ell_ry;
            ell_p = ry2 - rx2 * ell_ry + rx2 / 4;
            ell_region_two = 1'b0;
            ell_active = 1'b1;
            return g;
        end
        // step while idle: empty group
        if (!ell_active)
            return g;

        rx2 = ell_rx * ell_rx;
        ry2 = ell_ry * ell_ry;

        // region change: reload p with the quarter-integer value, truncated
        if (!ell_region_two && !(2 * ell_x * ry2 < 2 * ell_y * rx2))
        begin
            a = 2 * ell_x + 1;
            b = ell_y - 1;
            ell_p = (a * a * ry2 + 4 * b * b * rx2 - 4 * rx2 * ry2) / 4;
            ell_region_two = 1'b1;
            n_region_swap++;
        end

        g.valid_res = 1'b1;
        g.px_rt = OUT_BITS'(ell_cx + ell_x);
        g.py_rt = OUT_BITS'(ell_cy - ell_y);
        g.px_lb = OUT_BITS'(ell_cx - ell_x);
        g.py_lb = OUT_BITS'(ell_cy + ell_y);
        g.px_rb = OUT_BITS'(ell_cx + ell_x);
        g.py_rb = OUT_BITS'(ell_cy + ell_y);
        g.px_lt = OUT_BITS'(ell_cx - ell_x);
        g.py_lt = OUT_BITS'(ell_cy - ell_y);

        if (!ell_region_two)
        begin
            ell_x = ell_x + 1;
            if (ell_p < 0)
                ell_p = ell_p + 2 * ry2 * ell_x + ry2;
            else
            begin
                ell_y = ell_y - 1;
                ell_p = ell_p + 2 * ry2 * ell_x + ry2 - 2 * rx2 * ell_y;
            end
        end
        else
        begin
            ell_y = ell_y - 1;
            if (ell_p > 0)
                ell_p = ell_p + rx2 - 2 * rx2 * ell_y;
            else
            begin
                ell_x = ell_x + 1;
                ell_p = ell_p + 2 * ry2 * ell_x - 2 * rx2 * ell_y - rx2;
            end
        end

        // ellipse done once y drops below zero
        if (ell_region_two && ell_y < 0)
        begin
            g.last = 1'b1;
            ell_active = 1'b0;
        end
        return g;
    endfunction

    task automatic report_mismatch(string what, logic [OUT_BITS-1:0] got,
                                   logic [OUT_BITS-1:0] want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("MISMATCH %s: got 0x%h expected 0x%h (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    task automatic check_field(string what, logic [OUT_BITS-1:0] got,
                               logic [OUT_BITS-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        pixel_group_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_ready)
        begin
            if (expected_groups.size() == 0)
                report_mismatch("result with nothing outstanding", '0, '0);
            else
            begin
                want = expected_groups.pop_front();
                check_field("valid_res", OUT_BITS'(valid_res), OUT_BITS'(want.valid_res));
                check_field("last", OUT_BITS'(last), OUT_BITS'(want.last));
                check_field("px_right_top", px_right_top, want.px_rt);
                check_field("py_right_top", py_right_top, want.py_rt);
                check_field("px_left_bottom", px_left_bottom, want.px_lb);
                check_field("py_left_bottom", py_left_bottom, want.py_lb);
                check_field("px_right_bottom", px_right_bottom, want.px_rb);
                check_field("py_right_bottom", py_right_bottom, want.py_rb);
                check_field("px_left_top", px_left_top, want.px_lt);
                check_field("py_left_top", py_left_top, want.py_lt);
                if (want.valid_res)
                    n_groups++;
                if (want.last)
                    n_finished++;
            end
        end
    end

    // Send one request; predict its result once it is taken
    task automatic send_request(op_t op, logic signed [COORD_BITS-1:0] cx,
                                logic signed [COORD_BITS-1:0] cy,
                                logic [RADIUS_BITS-1:0] rx,
                                logic [RADIUS_BITS-1:0] ry);
        if (!quiet_mode && $urandom_range(99) < 15)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        req_valid <= 1'b1;
        operation <= op;
        center_x  <= cx;
        center_y  <= cy;
        radius_x  <= rx;
        radius_y  <= ry;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        expected_groups.push_back(rasterize(op, cx, cy, rx, ry));
        n_requests++;
    endtask

    // Step with junk in the ignored fields
    task automatic send_step();
        send_request(OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                     RADIUS_BITS'($urandom), RADIUS_BITS'($urandom));
    endtask

    // Step the current ellipse until it ends or the cap is hit
    task automatic step_until_done(int cap);
        int steps;
        steps = 0;
        while (ell_active && steps < cap)
        begin
            send_step();
            steps++;
        end
    endtask

    function automatic logic [RADIUS_BITS-1:0] pick_radius();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return RADIUS_BITS'($urandom_range(15));
        else if (roll < 97)
            return RADIUS_BITS'($urandom_range(63, 16));
        return RADIUS_BITS'($urandom);
    endfunction

    // Steps with no ellipse loaded, fields at both extremes
    task automatic test_idle_steps();
        send_request(OP_STEP, '0, '0, '0, '0);
        send_request(OP_STEP, '1, '1, '1, '1);
    endtask

    // Zero radii: straight to region 2, a single group when ry is zero, then idle
    task automatic test_degenerate_radii();
        send_request(OP_START, -12'sd2048, 12'sd2047, '0, '0);
        step_until_done(4);
        send_step();
        send_request(OP_START, 12'sd5, -12'sd7, '0, 10'd3);
        step_until_done(8);
        send_request(OP_START, -12'sd1, 12'sd1, 10'd4, '0);
        step_until_done(4);
    endtask

    // Largest radii, then a new start abandons the ellipse in flight
    task automatic test_restart_while_active();
        send_request(OP_START, 12'sd100, -12'sd100, 10'd1023, 10'd1023);
        repeat (3) send_step();
        send_request(OP_START, 12'sd2047, -12'sd2048, 10'd3, 10'd2);
        step_until_done(20);
    endtask

    // Mostly complete ellipses, some abandoned early, some stray steps
    task automatic test_random_ellipses();
        int first;
        int kind;
        first = n_requests;
        quiet_mode = 1'b1;
        while (n_requests - first < RANDOM_REQUESTS)
        begin
            if (n_requests - first > STEADY_REQUESTS)
                quiet_mode = 1'b0;
            kind = $urandom_range(99);
            if (kind < 8)
                send_step();
            else
            begin
                send_request(OP_START, COORD_BITS'($urandom), COORD_BITS'($urandom),
                             pick_radius(), pick_radius());
                if (kind < 20)
                    step_until_done($urandom_range(6));
                else
                    step_until_done(FULL_RUN_CAP);
            end
        end
        quiet_mode = 1'b0;
    endtask

    // Test sequence
    initial
    begin
        ell_active     = 1'b0;
        ell_region_two = 1'b0;
        ell_x  = 0;
        ell_y  = 0;
        ell_p  = 0;
        ell_cx = 0;
        ell_cy = 0;
        ell_rx = 0;
        ell_ry = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_steps();
        test_degenerate_radii();
        test_restart_while_active();
        test_random_ellipses();

        req_valid <= 1'b0;
        while (expected_groups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d requests, %0d pixel groups, %0d ellipses finished",
                 n_requests, n_groups, n_finished);
        $display("tb: %0d region changes, %0d mismatches", n_region_swap, n_errors);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
